// ===== rtl/owb_pkg.sv =====
// ----------------------------------------------------------------------------
// owb_pkg
// Shared types and constants of the 1-Wire bus master: phase and command
// codes, register indexes and reset values, configuration and result bundles.
// ----------------------------------------------------------------------------
package owb_pkg;

	localparam int unsigned REG_W     = 8;
	localparam int unsigned BIT_IDX_W = 3;

	// Register reset values
	localparam logic [REG_W-1:0] RESET_LOW_DEF      = 8'd50;
	localparam logic [REG_W-1:0] PRESENCE_WAIT_DEF  = 8'd7;
	localparam logic [REG_W-1:0] RESET_RECOVERY_DEF = 8'd41;
	localparam logic [REG_W-1:0] SHORT_PHASE_DEF    = 8'h01;
	localparam logic [REG_W-1:0] LONG_PHASE_DEF     = 8'd7;
	localparam logic [REG_W-1:0] READ_SAMPLE_DEF    = 8'h01;
	localparam logic [REG_W-1:0] READ_RECOVERY_DEF  = 8'd5;

	typedef enum logic [2:0] {
		REG_RESET_LOW      = 3'd0,
		REG_PRESENCE_WAIT  = 3'd1,
		REG_RESET_RECOVERY = 3'd2,
		REG_SHORT_PHASE    = 3'd3,
		REG_LONG_PHASE     = 3'd4,
		REG_READ_SAMPLE    = 3'd5,
		REG_READ_RECOVERY  = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_RESET = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_RST_LOW  = 3'd1,
		PH_RST_WAIT = 3'd2,
		PH_RST_REC  = 3'd3,
		PH_SLOT_LOW = 3'd4,
		PH_SLOT_REL = 3'd5,
		PH_RD_WAIT  = 3'd6,
		PH_RD_REC   = 3'd7
	} phase_t;

	typedef struct packed {
		logic [REG_W-1:0] reset_low;
		logic [REG_W-1:0] presence_wait;
		logic [REG_W-1:0] reset_recovery;
		logic [REG_W-1:0] short_phase;
		logic [REG_W-1:0] long_phase;
		logic [REG_W-1:0] read_sample;
		logic [REG_W-1:0] read_recovery;
	} owb_cfg_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy;
		logic       done;
		logic       presence;
		logic [7:0] read_data;
		logic       ignored;
	} owb_result_t;

endpackage

// ===== rtl/one_wire_bus_master.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master
// 1-Wire bus master stepped by tick items: reset with presence, byte write,
// byte read, all phase lengths from timing registers.
// ----------------------------------------------------------------------------
// Each accepted input item is one bus tick and yields exactly one result; a
// tick can be accepted every clock cycle, limited only by the two-entry
// result buffer filling while out_stall is held. Commands given while an
// operation runs are dropped and flagged in command_ignored. The user must
// write timing registers through cfg_we/cfg_index/cfg_wdata only while no
// operation is active; the block itself does not enforce this.
module one_wire_bus_master
	import owb_pkg::*;
#(
	parameter int unsigned BITS_PER_TRANSFER = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [REG_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       operation,
	input  logic [7:0]       write_data,
	input  logic             bus_level,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             drive_low,
	output logic             busy_res,
	output logic             done_res,
	output logic             presence_seen,
	output logic [7:0]       read_data,
	output logic             command_ignored
);

	owb_cfg_t    cfg;
	owb_result_t res;
	owb_result_t res_out;
	logic        acc;

	owb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	owb_core #(
		.BITS_PER_TRANSFER (BITS_PER_TRANSFER)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.operation  (operation),
		.write_data (write_data),
		.bus_level  (bus_level),
		.cfg        (cfg),
		.res        (res)
	);

	owb_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.acc       (acc),
		.res_in    (res),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_out   (res_out)
	);

	assign drive_low       = res_out.drive_low;
	assign busy_res        = res_out.busy;
	assign done_res        = res_out.done;
	assign presence_seen   = res_out.presence;
	assign read_data       = res_out.read_data;
	assign command_ignored = res_out.ignored;

endmodule

// ===== rtl/owb_regs.sv =====
// ----------------------------------------------------------------------------
// owb_regs
// Timing register file. Writes to an index past the last register are dropped.
// ----------------------------------------------------------------------------
module owb_regs
	import owb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [REG_W-1:0] cfg_wdata,
	output owb_cfg_t         cfg
);

	owb_cfg_t cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low      <= RESET_LOW_DEF;
			cfg_q.presence_wait  <= PRESENCE_WAIT_DEF;
			cfg_q.reset_recovery <= RESET_RECOVERY_DEF;
			cfg_q.short_phase    <= SHORT_PHASE_DEF;
			cfg_q.long_phase     <= LONG_PHASE_DEF;
			cfg_q.read_sample    <= READ_SAMPLE_DEF;
			cfg_q.read_recovery  <= READ_RECOVERY_DEF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RESET_LOW:      cfg_q.reset_low      <= cfg_wdata;
				REG_PRESENCE_WAIT:  cfg_q.presence_wait  <= cfg_wdata;
				REG_RESET_RECOVERY: cfg_q.reset_recovery <= cfg_wdata;
				REG_SHORT_PHASE:    cfg_q.short_phase    <= cfg_wdata;
				REG_LONG_PHASE:     cfg_q.long_phase     <= cfg_wdata;
				REG_READ_SAMPLE:    cfg_q.read_sample    <= cfg_wdata;
				REG_READ_RECOVERY:  cfg_q.read_recovery  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/owb_core.sv =====
// ----------------------------------------------------------------------------
// owb_core
// Phase sequencer: advances the tick counter and the phase on each accepted
// tick and forms that tick's result from the updated state.
// ----------------------------------------------------------------------------
module owb_core
	import owb_pkg::*;
#(
	parameter int unsigned BITS_PER_TRANSFER = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        acc,
	input  logic [1:0]  operation,
	input  logic [7:0]  write_data,
	input  logic        bus_level,
	input  owb_cfg_t    cfg,
	output owb_result_t res
);

	localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(BITS_PER_TRANSFER - 1);

	phase_t               phase_q, phase_d;
	logic [REG_W-1:0]     tick_q, tick_d;
	logic [BIT_IDX_W-1:0] bit_q, bit_d;
	logic [7:0]           shift_q, shift_d;
	op_t                  kind_q, kind_d;
	logic                 presence_q, presence_d;
	logic [7:0]           last_read_q, last_read_d;

	logic             wbit;
	logic [REG_W-1:0] len_raw;
	logic [REG_W-1:0] len;
	logic             phase_end;
	logic             ignored;
	logic             done;
	logic             drive;

	// next state and result of one tick
	always_comb begin
		phase_d     = phase_q;
		tick_d      = tick_q;
		bit_d       = bit_q;
		shift_d     = shift_q;
		kind_d      = kind_q;
		presence_d  = presence_q;
		last_read_d = last_read_q;
		ignored     = 1'b0;
		done        = 1'b0;
		drive       = 1'b0;
		len_raw     = '0;
		len         = '0;
		wbit        = 1'b0;
		phase_end   = 1'b0;

		// command decode
		if (phase_q == PH_IDLE) begin
			if (op_t'(operation) != OP_TICK) begin
				kind_d = op_t'(operation);
				tick_d = '0;
				bit_d  = '0;
				if (op_t'(operation) == OP_RESET) begin
					phase_d = PH_RST_LOW;
					shift_d = '0;
				end else begin
					phase_d = PH_SLOT_LOW;
					shift_d = (op_t'(operation) == OP_WRITE) ? write_data : 8'h00;
				end
			end
		end else if (op_t'(operation) != OP_TICK) begin
			ignored = 1'b1;
		end

		// phase length and timing
		if (phase_d != PH_IDLE) begin
			wbit = shift_d[bit_d];
			unique case (phase_d)
				PH_RST_LOW:  len_raw = cfg.reset_low;
				PH_RST_WAIT: len_raw = cfg.presence_wait;
				PH_RST_REC:  len_raw = cfg.reset_recovery;
				PH_SLOT_LOW: len_raw = (kind_d == OP_WRITE && !wbit) ?
				                       cfg.long_phase : cfg.short_phase;
				PH_SLOT_REL: len_raw = wbit ? cfg.long_phase : cfg.short_phase;
				PH_RD_WAIT:  len_raw = cfg.read_sample;
				PH_RD_REC:   len_raw = cfg.read_recovery;
				default:     len_raw = REG_W'(1);
			endcase
			// a zero length still lasts one tick
			len       = (len_raw == '0) ? REG_W'(1) : len_raw;
			drive     = (phase_d == PH_RST_LOW) || (phase_d == PH_SLOT_LOW);
			phase_end = ({1'b0, tick_d} + (REG_W+1)'(1)) >= {1'b0, len};

			if (phase_end) begin
				tick_d = '0;
				unique case (phase_d)
					PH_RST_LOW:  phase_d = PH_RST_WAIT;
					PH_RST_WAIT: begin
						presence_d = !bus_level;
						phase_d    = PH_RST_REC;
					end
					PH_RST_REC: begin
						phase_d = PH_IDLE;
						done    = 1'b1;
					end
					PH_SLOT_LOW: phase_d = (kind_d == OP_READ) ? PH_RD_WAIT : PH_SLOT_REL;
					PH_RD_WAIT: begin
						shift_d[bit_d] = shift_d[bit_d] | bus_level;
						phase_d        = PH_RD_REC;
					end
					PH_SLOT_REL, PH_RD_REC: begin
						// end of a bit slot
						if (bit_d >= LAST_BIT) begin
							if (kind_d == OP_READ) last_read_d = shift_d;
							phase_d = PH_IDLE;
							done    = 1'b1;
						end else begin
							bit_d   = bit_d + BIT_IDX_W'(1);
							phase_d = PH_SLOT_LOW;
						end
					end
					default: phase_d = PH_IDLE;
				endcase
			end else begin
				tick_d = tick_q + REG_W'(1);
			end
		end

		res.drive_low = drive;
		res.busy      = (phase_d != PH_IDLE);
		res.done      = done;
		res.presence  = presence_d;
		res.read_data = last_read_d;
		res.ignored   = ignored;
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tick_q      <= '0;
			bit_q       <= '0;
			shift_q     <= '0;
			kind_q      <= OP_TICK;
			presence_q  <= 1'b0;
			last_read_q <= '0;
		end else if (acc) begin
			phase_q     <= phase_d;
			tick_q      <= tick_d;
			bit_q       <= bit_d;
			shift_q     <= shift_d;
			kind_q      <= kind_d;
			presence_q  <= presence_d;
			last_read_q <= last_read_d;
		end
	end

	// checks
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> !res.busy)
		else $error("done and busy on the same tick");

	a_ignore_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.ignored |-> (phase_q != PH_IDLE))
		else $error("command flagged ignored while idle");

	a_idle_tick_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE && op_t'(operation) == OP_TICK) |->
		(!res.drive_low && !res.busy && !res.done))
		else $error("idle tick produced activity");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= LAST_BIT)
		else $error("bit index past last bit");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> (phase_q == $past(phase_q) && tick_q == $past(tick_q)))
		else $error("state moved without an accepted tick");

endmodule

// ===== rtl/owb_outbuf.sv =====
// ----------------------------------------------------------------------------
// owb_outbuf
// Two-entry result buffer: an output register plus a skid register, so a new
// tick is taken while a finished result still waits downstream.
// ----------------------------------------------------------------------------
module owb_outbuf
	import owb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	output logic        acc,
	input  owb_result_t res_in,
	output logic        out_valid,
	input  logic        out_stall,
	output owb_result_t res_out
);

	logic        out_valid_q;
	logic        skid_valid_q;
	owb_result_t out_q;
	owb_result_t skid_q;
	logic        take;

	assign in_stall = skid_valid_q;
	assign acc      = in_valid && !skid_valid_q;
	assign take     = out_valid_q && !out_stall;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q  <= skid_valid_q || acc;
				skid_valid_q <= skid_valid_q && acc;
			end else if (!out_valid_q) begin
				out_valid_q <= acc;
			end else if (acc) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (acc) skid_q <= res_in;
			end else if (acc) begin
				out_q <= res_in;
			end
		end else if (!out_valid_q) begin
			if (acc) out_q <= res_in;
		end else if (acc) begin
			skid_q <= res_in;
		end
	end

	assign out_valid = out_valid_q;
	assign res_out   = out_q;

	// checks
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry without output entry");

	a_skid_fills_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && acc) |=> skid_valid_q)
		else $error("accepted result lost behind a stalled output");

	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !acc)
		else $error("accept with both entries full");

endmodule

// ===== tb/sv/one_wire_bus_master_test.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master_test
// Self-checking bench for the 1-Wire bus master. A queue of tick transactions
// feeds a clocked driver, and a clocked monitor checks every result against a
// tick-exact software copy of the sequencer. The bench runs through several
// timing setups: reset values, zero lengths, small random lengths and the
// 255-tick extremes. Both channels idle at random, and the receiver holds off
// once for a long stretch so that the block has to stall its input.
// ----------------------------------------------------------------------------
module one_wire_bus_master_test;
	import owb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned XFER_BITS  = 8;
	localparam logic [2:0]  REG_NONE   = 3'd7;     // index with no register behind it
	localparam int          CYCLE_CAP  = 400000;
	localparam int          BUSY_PCT   = 33;
	localparam int          CALM_FROM  = 1000;     // window with no idling on either side
	localparam int          CALM_TO    = 1400;
	localparam int          HOLD_AT    = 100;
	localparam int          HOLD_LEN   = 60;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       level;
	} tick_t;

	// DUT ports; every input is known from time zero
	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [2:0]       cfg_index = '0;
	logic [REG_W-1:0] cfg_wdata = '0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	logic [1:0]       operation = OP_TICK;
	logic [7:0]       write_data = '0;
	logic             bus_level = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic             drive_low;
	logic             busy_res;
	logic             done_res;
	logic             presence_seen;
	logic [7:0]       read_data;
	logic             command_ignored;

	// Bench bookkeeping
	tick_t       tick_queue[$];
	owb_result_t bus_results[$];
	int          n_pushed = 0;
	int          n_acc    = 0;
	int          n_res    = 0;
	int          n_err    = 0;
	int          n_cyc    = 0;
	logic        in_acc   = 1'b0;
	int          hold_left = 0;
	logic        hold_done = 1'b0;
	owb_result_t want;
	owb_result_t step_out;

	// Software copy of the sequencer
	logic [7:0] m_cfg [0:6];
	phase_t     m_phase;
	logic [7:0] m_count;
	logic [2:0] m_bit;
	logic [7:0] m_shift;
	op_t        m_kind;
	logic       m_presence;
	logic [7:0] m_last_read;

	one_wire_bus_master #(
		.BITS_PER_TRANSFER(XFER_BITS)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.write_data     (write_data),
		.bus_level      (bus_level),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.drive_low      (drive_low),
		.busy_res       (busy_res),
		.done_res       (done_res),
		.presence_seen  (presence_seen),
		.read_data      (read_data),
		.command_ignored(command_ignored)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// A zero length register still gives a one-tick phase
	function automatic int ticks_of(input logic [7:0] r);
		return (r == 8'd0) ? 1 : int'(r);
	endfunction

	// Advance the sequencer copy by one tick transaction
	task automatic step_bus_master(input op_t op, input logic [7:0] wd, input logic lvl,
			output owb_result_t r);
		int len;
		r = '0;
		if (m_phase == PH_IDLE) begin
			if (op != OP_TICK) begin
				m_kind  = op;
				m_count = '0;
				m_bit   = '0;
				if (op == OP_RESET) begin
					m_phase = PH_RST_LOW;
					m_shift = '0;
				end else begin
					m_phase = PH_SLOT_LOW;
					m_shift = (op == OP_WRITE) ? wd : 8'h00;
				end
			end
		end else if (op != OP_TICK) begin
			r.ignored = 1'b1;
		end

		if (m_phase != PH_IDLE) begin
			case (m_phase)
				PH_RST_LOW:  len = ticks_of(m_cfg[REG_RESET_LOW]);
				PH_RST_WAIT: len = ticks_of(m_cfg[REG_PRESENCE_WAIT]);
				PH_RST_REC:  len = ticks_of(m_cfg[REG_RESET_RECOVERY]);
				PH_SLOT_LOW: len = (m_kind == OP_WRITE && !m_shift[m_bit]) ?
					ticks_of(m_cfg[REG_LONG_PHASE]) : ticks_of(m_cfg[REG_SHORT_PHASE]);
				PH_SLOT_REL: len = m_shift[m_bit] ?
					ticks_of(m_cfg[REG_LONG_PHASE]) : ticks_of(m_cfg[REG_SHORT_PHASE]);
				PH_RD_WAIT:  len = ticks_of(m_cfg[REG_READ_SAMPLE]);
				default:     len = ticks_of(m_cfg[REG_READ_RECOVERY]);
			endcase
			r.drive_low = (m_phase == PH_RST_LOW || m_phase == PH_SLOT_LOW);
			if (int'(m_count) + 1 >= len) begin
				m_count = '0;
				case (m_phase)
					PH_RST_LOW: m_phase = PH_RST_WAIT;
					PH_RST_WAIT: begin
						m_presence = !lvl;
						m_phase    = PH_RST_REC;
					end
					PH_RST_REC: begin
						m_phase = PH_IDLE;
						r.done  = 1'b1;
					end
					PH_SLOT_LOW: m_phase = (m_kind == OP_READ) ? PH_RD_WAIT : PH_SLOT_REL;
					PH_RD_WAIT: begin
						m_shift[m_bit] = m_shift[m_bit] | lvl;
						m_phase        = PH_RD_REC;
					end
					default: begin
						// end of a bit slot, write or read
						if (m_bit == 3'(XFER_BITS - 1)) begin
							if (m_kind == OP_READ)
								m_last_read = m_shift;
							m_phase = PH_IDLE;
							r.done  = 1'b1;
						end else begin
							m_bit   = m_bit + 3'd1;
							m_phase = PH_SLOT_LOW;
						end
					end
				endcase
			end else begin
				m_count = m_count + 8'd1;
			end
		end

		r.busy      = (m_phase != PH_IDLE);
		r.presence  = m_presence;
		r.read_data = m_last_read;
	endtask

	// Cycle limit
	always @(posedge clk) begin
		n_cyc++;
		if (n_cyc > CYCLE_CAP) begin
			$display("status: fail");
			$finish;
		end
	end

	// Monitor: register writes, result check, input transaction prediction
	always @(posedge clk) begin
		in_acc = in_valid && !in_stall;
		if (!arst_n) begin
			m_cfg[REG_RESET_LOW]      = RESET_LOW_DEF;
			m_cfg[REG_PRESENCE_WAIT]  = PRESENCE_WAIT_DEF;
			m_cfg[REG_RESET_RECOVERY] = RESET_RECOVERY_DEF;
			m_cfg[REG_SHORT_PHASE]    = SHORT_PHASE_DEF;
			m_cfg[REG_LONG_PHASE]     = LONG_PHASE_DEF;
			m_cfg[REG_READ_SAMPLE]    = READ_SAMPLE_DEF;
			m_cfg[REG_READ_RECOVERY]  = READ_RECOVERY_DEF;
			m_phase     = PH_IDLE;
			m_count     = '0;
			m_bit       = '0;
			m_shift     = '0;
			m_kind      = OP_TICK;
			m_presence  = 1'b0;
			m_last_read = '0;
			in_acc      = 1'b0;
		end else begin
			if (cfg_we && cfg_index <= REG_READ_RECOVERY)
				m_cfg[cfg_index] = cfg_wdata;

			if (out_valid && !out_stall) begin
				n_res++;
				if (bus_results.size() == 0) begin
					n_err++;
					if (n_err <= 10)
						$display("result %0d arrived with nothing expected", n_res);
				end else begin
					want = bus_results.pop_front();
					if (drive_low !== want.drive_low || busy_res !== want.busy ||
							done_res !== want.done || presence_seen !== want.presence ||
							read_data !== want.read_data || command_ignored !== want.ignored) begin
						n_err++;
						if (n_err <= 10)
							$display({"mismatch on result %0d (exp/act): drive %b/%b busy %b/%b",
								" done %b/%b presence %b/%b read %h/%h ignored %b/%b"},
								n_res, want.drive_low, drive_low, want.busy, busy_res,
								want.done, done_res, want.presence, presence_seen,
								want.read_data, read_data, want.ignored, command_ignored);
					end
				end
			end

			if (in_acc) begin
				n_acc++;
				step_bus_master(op_t'(operation), write_data, bus_level, step_out);
				bus_results.push_back(step_out);
			end
		end
	end

	// Driver: next tick transaction at the falling edge, held while stalled
	always @(negedge clk) begin
		if (!in_valid || in_acc) begin
			if (tick_queue.size() != 0 &&
					!(($urandom_range(99) < BUSY_PCT) && !(n_acc >= CALM_FROM && n_acc < CALM_TO))) begin
				in_valid   <= 1'b1;
				operation  <= tick_queue[0].op;
				write_data <= tick_queue[0].data;
				bus_level  <= tick_queue[0].level;
				void'(tick_queue.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall, with one long hold-off
	always @(negedge clk) begin
		if (!hold_done && n_res >= HOLD_AT) begin
			hold_left = HOLD_LEN;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (n_res >= CALM_FROM && n_res < CALM_TO) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < BUSY_PCT);
		end
	end

	task automatic add_tick(input op_t op, input logic [7:0] wd, input logic lvl);
		tick_t t;
		t.op    = op;
		t.data  = wd;
		t.level = lvl;
		tick_queue.push_back(t);
		n_pushed++;
	endtask

	// Whole operation: start command, then exactly as many ticks as it lasts,
	// some of them carrying stray commands that must be flagged
	task automatic add_operation(input op_t op, input int stray_pct);
		int len;
		case (op)
			OP_RESET: len = ticks_of(m_cfg[REG_RESET_LOW]) + ticks_of(m_cfg[REG_PRESENCE_WAIT]) +
				ticks_of(m_cfg[REG_RESET_RECOVERY]);
			OP_WRITE: len = XFER_BITS * (ticks_of(m_cfg[REG_SHORT_PHASE]) +
				ticks_of(m_cfg[REG_LONG_PHASE]));
			default:  len = XFER_BITS * (ticks_of(m_cfg[REG_SHORT_PHASE]) +
				ticks_of(m_cfg[REG_READ_SAMPLE]) + ticks_of(m_cfg[REG_READ_RECOVERY]));
		endcase
		add_tick(op, 8'($urandom), 1'($urandom));
		for (int i = 1; i < len; i++) begin
			if ($urandom_range(99) < stray_pct)
				add_tick(op_t'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
			else
				add_tick(OP_TICK, 8'($urandom), 1'($urandom));
		end
	endtask

	// Wait until every queued transaction is in and every result is out
	task automatic drain();
		while (n_acc != n_pushed || bus_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
	endtask

	// New timing setup, written only once the block has gone quiet
	task automatic apply_cfg(input logic [6:0][7:0] v);
		drain();
		repeat (4) @(negedge clk);
		for (int i = 0; i < 7; i++)
			cfg_write(3'(i), v[i]);
		cfg_write(REG_NONE, 8'($urandom));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [6:0][7:0] v;
		logic [7:0]      pat;
		int              start;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset timing values
		add_operation(OP_RESET, 0);
		add_operation(OP_READ, 10);
		add_operation(OP_WRITE, 0);

		// Directed part with every length zero, so each phase is one tick
		apply_cfg('0);
		add_tick(OP_TICK, 8'hFF, 1'b1);
		add_tick(OP_TICK, 8'h00, 1'b0);
		// reset answered by a device
		add_tick(OP_RESET, 8'h00, 1'b1);
		add_tick(OP_TICK, 8'hFF, 1'b0);
		add_tick(OP_TICK, 8'h00, 1'b1);
		// reset with no answer, stray commands mid-way and on the done tick
		add_tick(OP_RESET, 8'h00, 1'b0);
		add_tick(OP_WRITE, 8'hFF, 1'b1);
		add_tick(OP_READ, 8'h00, 1'b0);
		// byte write with mixed bits, stray reset in the middle
		add_tick(OP_WRITE, 8'hA5, 1'b0);
		for (int j = 1; j < 16; j++)
			add_tick((j == 7) ? OP_RESET : OP_TICK, 8'h5A, 1'($urandom));
		// byte read; the line is inverted away from the sample points
		pat = 8'h96;
		add_tick(OP_READ, 8'hFF, 1'b1);
		for (int j = 1; j < 24; j++)
			add_tick((j == 23) ? OP_WRITE : OP_TICK, 8'($urandom),
				(j % 3 == 1) ? pat[j / 3] : !pat[j / 3]);
		// back-to-back start right after done
		add_tick(OP_RESET, 8'h00, 1'b1);
		add_tick(OP_TICK, 8'h00, 1'b0);
		add_tick(OP_TICK, 8'h00, 1'b0);

		// Random part: short timings, mostly well-formed operations
		repeat (4) begin
			for (int i = 0; i < 7; i++)
				v[i] = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
			apply_cfg(v);
			start = n_pushed;
			while (n_pushed - start < 120) begin
				repeat ($urandom_range(0, 3))
					add_tick(($urandom_range(9) == 0) ? op_t'($urandom_range(1, 3)) : OP_TICK,
						8'($urandom), 1'($urandom));
				// a stray start on an idle tick begins a real operation; keep it whole
				drain();
				if (m_phase != PH_IDLE) begin
					while (m_phase != PH_IDLE) begin
						add_tick(OP_TICK, 8'($urandom), 1'($urandom));
						drain();
					end
				end
				add_operation(op_t'($urandom_range(1, 3)), 6);
			end
		end

		// Extremes: every reset phase at its 255-tick maximum
		v = {7{8'd255}};
		apply_cfg(v);
		add_operation(OP_RESET, 2);

		drain();
		repeat (16) @(negedge clk);
		if (bus_results.size() != 0)
			n_err++;
		if (n_err == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
